// ===== design/pki_pkg.sv =====
package pki_pkg;

  localparam int unsigned NumSlots     = 3;
  localparam int unsigned MacWidth     = 48;
  localparam int unsigned TimeWidth    = 32;
  localparam int unsigned GraceMsWidth = 16;
  localparam int unsigned AddrWidth    = 6;
  localparam int unsigned DataWidth    = 64;
  localparam int unsigned DetectHoldMs = 3000;
  localparam int unsigned LostHoldMs   = 5000;
  localparam int unsigned MsPerSecond  = 1000;

  typedef enum logic [1:0] {
    OP_TICK       = 2'd0,
    OP_SCAN       = 2'd1,
    OP_ENGINE_OFF = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    REG_ENABLE     = 3'd0,
    REG_THRESHOLD  = 3'd1,
    REG_GRACE      = 3'd2,
    REG_MAC_0      = 3'd3,
    REG_MAC_1      = 3'd4,
    REG_MAC_2      = 3'd5,
    REG_VALID_MASK = 3'd6
  } reg_e;

  typedef struct packed {
    logic                                enable;
    logic signed [7:0]                   threshold;
    logic [5:0]                          grace_seconds;
    logic [NumSlots-1:0][MacWidth-1:0]   mac;
    logic [NumSlots-1:0]                 valid_mask;
  } cfg_t;

  typedef struct packed {
    op_e                  op;
    logic [TimeWidth-1:0] now_ms;
    logic                 engine_running;
    logic [NumSlots-1:0]  match;
    logic                 rssi_ok;
  } cmd_t;

  typedef struct packed {
    logic ignition_allowed;
    logic phone_confirmed;
    logic grace_in_progress;
    logic engine_has_run;
  } status_t;

endpackage

// ===== design/pki_if.sv =====
interface pki_req_if;
  logic              valid;
  logic              ready;
  logic [1:0]        operation;
  logic [31:0]       now_ms;
  logic              engine_running;
  logic [47:0]       device_mac;
  logic signed [7:0] signal_dbm;

  modport source (
    output valid, operation, now_ms, engine_running, device_mac, signal_dbm,
    input  ready
  );
  modport sink (
    input  valid, operation, now_ms, engine_running, device_mac, signal_dbm,
    output ready
  );
endinterface

interface pki_rsp_if;
  logic valid;
  logic ready;
  logic ignition_allowed;
  logic phone_confirmed;
  logic grace_in_progress;
  logic engine_has_run;

  modport source (
    output valid, ignition_allowed, phone_confirmed, grace_in_progress, engine_has_run,
    input  ready
  );
  modport sink (
    input  valid, ignition_allowed, phone_confirmed, grace_in_progress, engine_has_run,
    output ready
  );
endinterface

// ===== design/pki_regs.sv =====
module pki_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [pki_pkg::AddrWidth-1:0]  paddr,
  input  logic [pki_pkg::DataWidth-1:0]  pwdata,
  output logic [pki_pkg::DataWidth-1:0]  prdata,
  output logic                           pready,
  output pki_pkg::cfg_t                  cfg_o
);
  import pki_pkg::*;

  cfg_t cfg_q, cfg_d;
  logic wr_en;
  reg_e reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = reg_e'(paddr[AddrWidth-1:3]);
  assign cfg_o   = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        REG_ENABLE:     cfg_d.enable        = pwdata[0];
        REG_THRESHOLD:  cfg_d.threshold     = $signed(pwdata[7:0]);
        REG_GRACE:      cfg_d.grace_seconds = pwdata[5:0];
        REG_MAC_0:      cfg_d.mac[0]        = pwdata[MacWidth-1:0];
        REG_MAC_1:      cfg_d.mac[1]        = pwdata[MacWidth-1:0];
        REG_MAC_2:      cfg_d.mac[2]        = pwdata[MacWidth-1:0];
        REG_VALID_MASK: cfg_d.valid_mask    = pwdata[NumSlots-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_idx)
      REG_ENABLE:     prdata[0]            = cfg_q.enable;
      REG_THRESHOLD:  prdata[7:0]          = cfg_q.threshold;
      REG_GRACE:      prdata[5:0]          = cfg_q.grace_seconds;
      REG_MAC_0:      prdata[MacWidth-1:0] = cfg_q.mac[0];
      REG_MAC_1:      prdata[MacWidth-1:0] = cfg_q.mac[1];
      REG_MAC_2:      prdata[MacWidth-1:0] = cfg_q.mac[2];
      REG_VALID_MASK: prdata[NumSlots-1:0] = cfg_q.valid_mask;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable        <= 1'b0;
      cfg_q.threshold     <= -8'sd65;
      cfg_q.grace_seconds <= 6'd10;
      cfg_q.mac           <= '0;
      cfg_q.valid_mask    <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ===== design/pki_front.sv =====
module pki_front (
  pki_req_if.sink         req,
  input  pki_pkg::cfg_t   cfg_i,
  input  logic            queue_ready_i,
  output logic            push_o,
  output pki_pkg::cmd_t   cmd_o
);
  import pki_pkg::*;

  logic [NumSlots-1:0] match;

  always_comb begin
    for (int i = 0; i < NumSlots; i++) begin
      match[i] = cfg_i.valid_mask[i] && (cfg_i.mac[i] == req.device_mac);
    end
  end

  assign req.ready            = queue_ready_i;
  assign push_o               = req.valid && queue_ready_i;
  assign cmd_o.op             = op_e'(req.operation);
  assign cmd_o.now_ms         = req.now_ms;
  assign cmd_o.engine_running = req.engine_running;
  assign cmd_o.match          = match;
  assign cmd_o.rssi_ok        = (req.signal_dbm >= cfg_i.threshold);

endmodule

// ===== design/pki_queue.sv =====
module pki_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  pki_pkg::cmd_t  cmd_i,
  output logic           ready_o,
  input  logic           pop_i,
  output logic           valid_o,
  output pki_pkg::cmd_t  cmd_o
);
  import pki_pkg::*;

  cmd_t       mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  assign ready_o = (count_q != 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign cmd_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// ===== design/pki_back.sv =====
module pki_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  pki_pkg::cfg_t  cfg_i,
  input  logic           valid_i,
  input  pki_pkg::cmd_t  cmd_i,
  output logic           pop_o,
  pki_rsp_if.source      rsp
);
  import pki_pkg::*;

  logic [NumSlots-1:0]     seen_q, seen_d;
  logic                    present_q, present_d;
  logic                    granted_q, granted_d;
  logic                    ran_q, ran_d;
  logic                    grace_q, grace_d;
  logic [TimeWidth-1:0]    grace_start_q, grace_start_d;
  logic [TimeWidth-1:0]    first_seen_q, first_seen_d;
  logic [TimeWidth-1:0]    last_seen_q, last_seen_d;
  logic                    out_valid_q;
  status_t                 status_q;

  logic                    any_seen;
  logic                    active;
  logic [TimeWidth-1:0]    first_eff;
  logic [TimeWidth-1:0]    since_first;
  logic [TimeWidth-1:0]    since_last;
  logic [TimeWidth-1:0]    since_grace;
  logic [GraceMsWidth-1:0] grace_ms;

  assign pop_o       = valid_i && (!out_valid_q || rsp.ready);
  assign any_seen    = |(seen_q & cfg_i.valid_mask);
  assign active      = cfg_i.enable && (|cfg_i.valid_mask);
  assign first_eff   = (first_seen_q == '0) ? cmd_i.now_ms : first_seen_q;
  assign since_first = cmd_i.now_ms - first_eff;
  assign since_last  = cmd_i.now_ms - last_seen_q;
  assign since_grace = cmd_i.now_ms - grace_start_q;
  assign grace_ms    = GraceMsWidth'(cfg_i.grace_seconds) * GraceMsWidth'(MsPerSecond);

  always_comb begin
    seen_d        = seen_q;
    present_d     = present_q;
    granted_d     = granted_q;
    ran_d         = ran_q;
    grace_d       = grace_q;
    grace_start_d = grace_start_q;
    first_seen_d  = first_seen_q;
    last_seen_d   = last_seen_q;
    case (cmd_i.op)
      OP_TICK: begin
        if (!active) begin
          granted_d = 1'b0;
          present_d = 1'b0;
        end else begin
          if (any_seen && !present_q) begin
            first_seen_d = first_eff;
            if (since_first >= TimeWidth'(DetectHoldMs)) begin
              present_d   = 1'b1;
              last_seen_d = cmd_i.now_ms;
              granted_d   = 1'b1;
              grace_d     = 1'b0;
            end
          end else if (any_seen) begin
            last_seen_d  = cmd_i.now_ms;
            first_seen_d = cmd_i.now_ms;
          end else begin
            first_seen_d = '0;
            if (present_q && since_last >= TimeWidth'(LostHoldMs)) begin
              present_d = 1'b0;
              if (!ran_q) begin
                granted_d = 1'b0;
              end
            end
          end
          if (granted_d && cmd_i.engine_running) begin
            ran_d = 1'b1;
          end
          if (grace_d) begin
            if (since_grace >= TimeWidth'(grace_ms)) begin
              grace_d   = 1'b0;
              granted_d = 1'b0;
              ran_d     = 1'b0;
            end
            if (cmd_i.engine_running) begin
              grace_d = 1'b0;
              ran_d   = 1'b1;
            end
          end
        end
      end
      OP_SCAN: begin
        seen_d = (seen_q & ~cmd_i.match) | (cmd_i.match & {NumSlots{cmd_i.rssi_ok}});
      end
      OP_ENGINE_OFF: begin
        if (cfg_i.enable && granted_q && ran_q && !grace_q && !present_q) begin
          grace_d       = 1'b1;
          grace_start_d = cmd_i.now_ms;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q        <= '0;
      present_q     <= 1'b0;
      granted_q     <= 1'b0;
      ran_q         <= 1'b0;
      grace_q       <= 1'b0;
      grace_start_q <= '0;
      first_seen_q  <= '0;
      last_seen_q   <= '0;
    end else if (pop_o) begin
      seen_q        <= seen_d;
      present_q     <= present_d;
      granted_q     <= granted_d;
      ran_q         <= ran_d;
      grace_q       <= grace_d;
      grace_start_q <= grace_start_d;
      first_seen_q  <= first_seen_d;
      last_seen_q   <= last_seen_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      out_valid_q <= 1'b1;
    end else if (rsp.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      status_q.ignition_allowed  <= granted_d;
      status_q.phone_confirmed   <= present_d;
      status_q.grace_in_progress <= grace_d;
      status_q.engine_has_run    <= ran_d;
    end
  end

  assign rsp.valid             = out_valid_q;
  assign rsp.ignition_allowed  = status_q.ignition_allowed;
  assign rsp.phone_confirmed   = status_q.phone_confirmed;
  assign rsp.grace_in_progress = status_q.grace_in_progress;
  assign rsp.engine_has_run    = status_q.engine_has_run;

endmodule

// ===== design/proximity_keyless_ignition_fsm.sv =====
// Keyless ignition controller that grants ignition while a paired phone is near. Each
// request (tick, scan report or engine-off event) yields exactly one status response
// carrying the state after that request. The block takes one request per clock cycle
// while its queue has room: the front end matches the reported address against the paired
// slots and writes a command into a two-entry queue, and the back end applies one command
// per cycle unless the last response waits untaken, to the presence, grant and grace state
// and places the status in an output register. The queue keeps accepting while a response
// waits to be taken. Registers are written over the APB port at byte address 8 times their
// index; the user must write them only while no request is in flight, which the block does not enforce.
module proximity_keyless_ignition_fsm (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  pki_req_if.sink                        req_i,
  pki_rsp_if.source                      rsp_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [pki_pkg::AddrWidth-1:0]  paddr,
  input  logic [pki_pkg::DataWidth-1:0]  pwdata,
  output logic [pki_pkg::DataWidth-1:0]  prdata,
  output logic                           pready
);
  import pki_pkg::*;

  cfg_t cfg;
  cmd_t front_cmd;
  cmd_t back_cmd;
  logic push;
  logic queue_ready;
  logic queue_valid;
  logic pop;

  pki_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  pki_front u_front (
    .req           (req_i),
    .cfg_i         (cfg),
    .queue_ready_i (queue_ready),
    .push_o        (push),
    .cmd_o         (front_cmd)
  );

  pki_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (front_cmd),
    .ready_o (queue_ready),
    .pop_i   (pop),
    .valid_o (queue_valid),
    .cmd_o   (back_cmd)
  );

  pki_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .valid_i (queue_valid),
    .cmd_i   (back_cmd),
    .pop_o   (pop),
    .rsp     (rsp_o)
  );

`ifndef SYNTHESIS
  // A grace countdown only runs after the engine has run in this unlock cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> (!rsp_o.grace_in_progress || rsp_o.engine_has_run))
    else $error("grace running without engine run");

  // Confirmed presence always comes with a grant and never with a grace countdown.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> (!rsp_o.phone_confirmed ||
                     (rsp_o.ignition_allowed && !rsp_o.grace_in_progress)))
    else $error("confirmed presence without grant or with grace");

  // The queue never takes a command that it has no room for.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (queue_valid && !queue_ready && !pop) |=> !queue_ready)
    else $error("queue lost its full state without a pop");
`endif

endmodule
